/* rtl/b64d_pkg.sv */
// Shared types and character constants for the base64url stream decoder.
package b64d_pkg;

  typedef enum logic [1:0] {
    SymData,
    SymPad,
    SymBad
  } sym_kind_e;

  typedef struct packed {
    sym_kind_e  kind;
    logic [5:0] value;
  } sym_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       bad_char;
    logic       end_of_string;
  } result_t;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChEquals = 8'h3d;

  localparam logic [7:0] LowerBase = 8'd26;
  localparam logic [7:0] DigitBase = 8'd52;
  localparam logic [5:0] SymPlus   = 6'd62;
  localparam logic [5:0] SymSlash  = 6'd63;

  // Pending bit count, held in pairs of bits.
  localparam logic [1:0] PairsNone = 2'd0;
  localparam logic [1:0] PairsTwo  = 2'd1;
  localparam logic [1:0] PairsFour = 2'd2;
  localparam logic [1:0] PairsSix  = 2'd3;

endpackage

/* rtl/b64d_lookup.sv */
// Character classifier that maps one character to its six-bit symbol value.
module b64d_lookup import b64d_pkg::*; (
  input  logic [7:0] char_code_i,
  input  logic       standard_i,
  output sym_t       sym_o
);

  logic [7:0] upper_val;
  logic [7:0] lower_val;
  logic [7:0] digit_val;

  assign upper_val = char_code_i - ChUpperA;
  assign lower_val = char_code_i - ChLowerA + LowerBase;
  assign digit_val = char_code_i - ChDigit0 + DigitBase;

  always_comb begin
    sym_o.kind  = SymBad;
    sym_o.value = '0;
    priority if (char_code_i >= ChUpperA && char_code_i <= ChUpperZ) begin
      sym_o.kind  = SymData;
      sym_o.value = upper_val[5:0];
    end else if (char_code_i >= ChLowerA && char_code_i <= ChLowerZ) begin
      sym_o.kind  = SymData;
      sym_o.value = lower_val[5:0];
    end else if (char_code_i >= ChDigit0 && char_code_i <= ChDigit9) begin
      sym_o.kind  = SymData;
      sym_o.value = digit_val[5:0];
    end else if (char_code_i == ChMinus || (standard_i && char_code_i == ChPlus)) begin
      sym_o.kind  = SymData;
      sym_o.value = SymPlus;
    end else if (char_code_i == ChUnder || (standard_i && char_code_i == ChSlash)) begin
      sym_o.kind  = SymData;
      sym_o.value = SymSlash;
    end else if (char_code_i == ChEquals) begin
      sym_o.kind  = SymPad;
    end else begin
      sym_o.kind  = SymBad;
    end
  end

endmodule

/* rtl/b64d_accum.sv */
// Bit accumulator and sticky error flag that turn symbols into decoded bytes.
module b64d_accum import b64d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  input  sym_t    sym_i,
  output result_t res_o
);

  logic [5:0] store_q, store_d, store_base;
  logic [1:0] pairs_q, pairs_d, pairs_base;
  logic       err_q, err_d, err_base;

  assign store_base = item_i.first ? 6'd0      : store_q;
  assign pairs_base = item_i.first ? PairsNone : pairs_q;
  assign err_base   = item_i.first ? 1'b0      : err_q;

  always_comb begin
    store_d        = store_base;
    pairs_d        = pairs_base;
    err_d          = err_base;
    res_o.byte_valid    = 1'b0;
    res_o.out_byte      = 8'd0;
    res_o.end_of_string = item_i.last;
    if (!err_base) begin
      unique case (sym_i.kind)
        SymBad: begin
          err_d = 1'b1;
        end
        SymData: begin
          unique case (pairs_base)
            PairsNone: begin
              store_d = sym_i.value;
              pairs_d = PairsSix;
            end
            PairsTwo: begin
              res_o.byte_valid = 1'b1;
              res_o.out_byte   = {store_base[1:0], sym_i.value};
              store_d          = 6'd0;
              pairs_d          = PairsNone;
            end
            PairsFour: begin
              res_o.byte_valid = 1'b1;
              res_o.out_byte   = {store_base[3:0], sym_i.value[5:2]};
              store_d          = {4'd0, sym_i.value[1:0]};
              pairs_d          = PairsTwo;
            end
            PairsSix: begin
              res_o.byte_valid = 1'b1;
              res_o.out_byte   = {store_base, sym_i.value[5:4]};
              store_d          = {2'd0, sym_i.value[3:0]};
              pairs_d          = PairsFour;
            end
            default: begin
              pairs_d = pairs_base;
            end
          endcase
        end
        default: begin
          store_d = store_base;
        end
      endcase
    end
    res_o.bad_char = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      pairs_q <= PairsNone;
      err_q   <= 1'b0;
    end else if (adv_i) begin
      store_q <= store_d;
      pairs_q <= pairs_d;
      err_q   <= err_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The unused high bits of the store are always kept clear.
  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pairs_q != PairsNone || store_q == 6'd0) &&
    (pairs_q != PairsTwo  || store_q[5:2] == 4'd0) &&
    (pairs_q != PairsFour || store_q[5:4] == 2'd0))
    else $error("accumulator store holds bits beyond its count");

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && err_q && !item_i.first |-> !res_o.byte_valid)
    else $error("byte produced while the string is in error");
`endif

endmodule

/* rtl/base64url_stream_decoder.sv */
// Top level of the base64url stream decoder: word pipeline, mode register and result register.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------------
//   input    | in_valid_i / in_stall_o  | char_code_i, first_i, last_i
//   output   | out_valid_o / out_stall_i| byte_valid_o, out_byte_o, bad_char_o,
//            |                          | end_of_string_o
//   config   | cfg_we_i                 | cfg_wdata_i (standard alphabet mode)
//
// One word is accepted per cycle while in_stall_o is low and passes from the input register
// to the result register; the accumulator update is combinational logic between the two.
// Reset clears the accumulator, error flag, mode register and both stage valid flags.
// A stall on the output while a result is held keeps the result register and, once the
// input stage is full, raises in_stall_o in the same cycle.
module base64url_stream_decoder import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       first_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic       bad_char_o,
  output logic       end_of_string_o
);

  logic    standard_q;
  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res;
  sym_t    sym;
  logic    in_load;
  logic    out_free;
  logic    s1_adv;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_load || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  b64d_lookup u_lookup (
    .char_code_i (s1_item_q.char_code),
    .standard_i  (standard_q),
    .sym_o       (sym)
  );

  b64d_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .item_i (s1_item_q),
    .sym_i  (sym),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      standard_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        standard_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_item_q <= '{char_code: char_code_i, first: first_i, last: last_i};
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_valid_o    = out_res_q.byte_valid;
  assign out_byte_o      = out_res_q.out_byte;
  assign bad_char_o      = out_res_q.bad_char;
  assign end_of_string_o = out_res_q.end_of_string;

`ifndef NO_ASSERTIONS
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input stage");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("word left the input stage but no result was registered");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.byte_valid |-> out_res_q.out_byte == 8'd0)
    else $error("non-zero byte reported without a decoded byte");
`endif

endmodule
